>>> rtl/tpe_pkg.sv
// Package for the timer pool expiry engine: widths, command and result codes,
// and the queue entry type. No dependencies.
package tpe_pkg;
  localparam int unsigned NumSlots = 16;
  localparam int unsigned IdW      = 4;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned DelayW   = 32;
  localparam int unsigned TickW    = 16;

  typedef enum logic [1:0] {
    CMD_ADD_ONCE   = 2'd0,
    CMD_ADD_REPEAT = 2'd1,
    CMD_CANCEL     = 2'd2,
    CMD_TICK       = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_FIRED     = 3'd4
  } kind_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DelayW-1:0] delay;
    logic [IdW-1:0]    sid;
  } cmd_t;

  typedef struct packed {
    kind_e          kind;
    logic [IdW-1:0] id;
    logic           last;
  } res_t;
endpackage

>>> rtl/tpe_front.sv
// Front end: accepts commands into a two-entry queue.
// Depends on tpe_pkg.
module tpe_front import tpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output cmd_t q_cmd_o
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_cmd_o    = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/tpe_back.sv
// Back end: runs commands on the slot pool, scanning one slot per cycle on
// ticks unless output stalls; results sit in an output register. Uses tpe_pkg.
module tpe_back import tpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [TickW-1:0] tick_len_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  cmd_t             q_cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output res_t             out_res_o,
  output logic             busy_o
);
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e             state_q;
  logic [TimeW-1:0]   now_q;
  logic [NumSlots-1:0] act_q, rep_q;
  logic [TimeW-1:0]   exp_q [NumSlots];
  logic [DelayW-1:0]  int_q [NumSlots];
  logic [IdW-1:0]     idx_q;
  logic               pend_q;     // a fired result waits to learn if it is last
  logic [IdW-1:0]     pend_id_q;
  logic               ov_q;
  res_t               ov_res_q;

  logic               free_any;
  logic [IdW-1:0]     free_idx;
  logic               out_free;
  logic               hit;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_any = 1'b1;
        free_idx = IdW'(i);
      end
    end
  end

  assign out_free    = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_res_o   = ov_res_q;
  assign hit = act_q[idx_q] && (exp_q[idx_q] <= now_q);
  assign q_ready_o = (state_q == ST_IDLE) && out_free;
  assign busy_o = (state_q != ST_IDLE) || ov_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i && out_free &&
        (q_cmd_i.cmd == CMD_ADD_ONCE || q_cmd_i.cmd == CMD_ADD_REPEAT) && free_any) begin
      exp_q[free_idx] <= now_q + TimeW'(q_cmd_i.delay);
      int_q[free_idx] <= q_cmd_i.delay;
    end else if (state_q == ST_SCAN && out_free && hit && rep_q[idx_q]) begin
      exp_q[idx_q] <= now_q + TimeW'(int_q[idx_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; now_q <= '0; act_q <= '0; rep_q <= '0;
      idx_q <= '0; pend_q <= 1'b0; pend_id_q <= '0; ov_q <= 1'b0;
      ov_res_q <= '{kind: KIND_ADDED, id: '0, last: 1'b0};
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i && out_free) begin
            case (q_cmd_i.cmd)
              CMD_ADD_ONCE, CMD_ADD_REPEAT: begin
                ov_q <= 1'b1;
                if (free_any) begin
                  act_q[free_idx] <= 1'b1;
                  rep_q[free_idx] <= q_cmd_i.cmd == CMD_ADD_REPEAT;
                  ov_res_q <= '{kind: KIND_ADDED, id: free_idx, last: 1'b1};
                end else begin
                  ov_res_q <= '{kind: KIND_FULL, id: '0, last: 1'b1};
                end
              end
              CMD_CANCEL: begin
                ov_q <= 1'b1;
                if (act_q[q_cmd_i.sid]) begin
                  act_q[q_cmd_i.sid] <= 1'b0;
                  rep_q[q_cmd_i.sid] <= 1'b0;
                  ov_res_q <= '{kind: KIND_CANCELLED, id: q_cmd_i.sid, last: 1'b1};
                end else begin
                  ov_res_q <= '{kind: KIND_NOT_FOUND, id: q_cmd_i.sid, last: 1'b1};
                end
              end
              default: begin
                now_q   <= now_q + TimeW'(tick_len_i);
                idx_q   <= '0;
                pend_q  <= 1'b0;
                state_q <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Fired slots wait in pend_q so the final one can be marked last.
          if (out_free) begin
            if (hit) begin
              if (!rep_q[idx_q]) act_q[idx_q] <= 1'b0;
              if (pend_q) begin
                ov_q <= 1'b1;
                ov_res_q <= '{kind: KIND_FIRED, id: pend_id_q, last: 1'b0};
              end
              pend_q <= 1'b1;
              pend_id_q <= idx_q;
            end
            if (idx_q == IdW'(NumSlots - 1)) begin
              state_q <= ST_IDLE;
              if (hit) begin
                if (pend_q) begin
                  // Two results at once: older now, last in ST_FLUSH.
                  state_q <= ST_FLUSH;
                end else begin
                  ov_q <= 1'b1;
                  ov_res_q <= '{kind: KIND_FIRED, id: idx_q, last: 1'b1};
                  pend_q <= 1'b0;
                end
              end else if (pend_q) begin
                ov_q <= 1'b1;
                ov_res_q <= '{kind: KIND_FIRED, id: pend_id_q, last: 1'b1};
                pend_q <= 1'b0;
              end
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            ov_q <= 1'b1;
            ov_res_q <= '{kind: KIND_FIRED, id: pend_id_q, last: 1'b1};
            pend_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/timer_pool_expiry_engine_top.sv
// Timer pool expiry engine, 16 slots; add and cancel each give one result.
// A tick scans one slot per cycle unless output stalls, via the single shared
// expiry comparator. A two-entry command queue accepts items during a scan.
// Reset (rst_ni low, asynchronous) clears time, slots and tick length to 1.
// Depends on tpe_pkg, tpe_front, tpe_back.
module timer_pool_expiry_engine_top import tpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // command[1:0], delay[33:2], slot_id[37:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // kind[2:0], timer_id[6:3]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i     // tick_length_ms
);
  logic [TickW-1:0] tick_len_q;
  logic q_valid, q_ready, busy;
  cmd_t in_cmd, q_cmd;
  res_t res;

  assign in_cmd = '{cmd: cmd_e'(s_axis_tdata[1:0]), delay: s_axis_tdata[33:2],
                    sid: s_axis_tdata[37:34]};
  // The tick length only changes while no command is queued or executing.
  assign cfg_ready_o = !busy && !q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tick_len_q <= TickW'(1);
    else if (cfg_valid_i && cfg_ready_o) tick_len_q <= cfg_data_i;
  end

  tpe_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_cmd_i(in_cmd), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  tpe_back u_back (
    .clk_i, .rst_ni, .tick_len_i(tick_len_q), .q_valid_i(q_valid),
    .q_ready_o(q_ready), .q_cmd_i(q_cmd), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .out_res_o(res), .busy_o(busy)
  );

  assign m_axis_tdata = {1'b0, res.id, res.kind};
  assign m_axis_tlast = res.last;
endmodule

>>> rtl/tpe_checker.sv
// Port-level checker for the timer pool expiry engine, bound to the top level.
// Depends on tpe_pkg for the result codes.
module tpe_checker import tpe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= KIND_FIRED) else $error("bad kind");
  a_nonfire_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != KIND_FIRED |-> m_axis_tlast)
    else $error("single result not last");
  a_full_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == KIND_FULL |-> m_axis_tdata[6:3] == 4'd0)
    else $error("full with nonzero id");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");
endmodule

bind timer_pool_expiry_engine_top tpe_checker u_checker (.*);
